@@ hw/rtl/heat_eq_pkg.sv @@
// Package for the explicit heat equation step block.
// Holds the operation and register codes, the sequencer states and the fixed-point widths.
// Depends on nothing.
package heat_eq_pkg;

  localparam int TEMP_W = 16;
  localparam int COEF_W = 16;
  localparam int GAIN_W = 16;
  localparam int CELLS_W = 6;
  localparam int IDX_W = 5;
  localparam int OP_W = 2;

  localparam int MUL_W = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = 51;
  localparam int BRK_MSB = 33;
  localparam int BRK_SPLIT = 17;
  localparam int FRAC_SHIFT = 30;
  localparam int INC_W = ACC_W - FRAC_SHIFT;
  localparam int SUM_W = INC_W + 1;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (FRAC_SHIFT - 1));
  localparam logic signed [SUM_W-1:0] TEMP_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] TEMP_MIN = -SUM_W'(32768);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_USE = 1'b1;
  localparam logic [CELLS_W-1:0] CELLS_RESET = 6'd20;
  localparam logic [CELLS_W-1:0] CELLS_MIN = 6'd3;

  typedef enum logic [OP_W-1:0] {
    OP_WR_TEMP = 2'd0,
    OP_WR_COEF = 2'd1,
    OP_STEP    = 2'd2,
    OP_RD_TEMP = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_HEAD,
    ST_PRIME,
    ST_EMIT0,
    ST_MUL_L,
    ST_MUL_R,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_WRITE,
    ST_TAIL
  } state_e;

endpackage

@@ hw/rtl/heat_equation_explicit_step.sv @@
// Top level of the explicit heat equation step: grid memories, sequencer and shared multiplier.
// Depends on heat_eq_pkg.
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_stall_o   operation, cell_index, temperature, coefficient
//   out      output     out_valid_o / out_stall_i cell_index_out, temperature_out, saturated, last
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A read word passes the memory read register and then the output register.
// In a step every interior cell passes the one 18 by 18 multiplier four times and then
// a write-back state.
// No clearing pass follows reset; the grid is undefined until loaded.
// A stalled output word holds the sequencer in the state that produces the next word.
module heat_equation_explicit_step
  import heat_eq_pkg::*;
#(
  parameter int MAX_CELLS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [GAIN_W-1:0]           cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [OP_W-1:0]             operation_i,
  input  logic [IDX_W-1:0]            cell_index_i,
  input  logic signed [TEMP_W-1:0]    temperature_in_i,
  input  logic [COEF_W-1:0]           coefficient_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [IDX_W-1:0]            cell_index_out_o,
  output logic signed [TEMP_W-1:0]    temperature_out_o,
  output logic                        saturated_o,
  output logic                        last_o
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);

  state_e state_q, state_d;

  logic [GAIN_W-1:0] gain_q;
  logic [CELLS_W-1:0] cells_q;
  logic [CW-1:0] n_cells;

  logic signed [TEMP_W-1:0] temps [MAX_CELLS];
  logic [COEF_W-1:0] coefs [MAX_CELLS];
  logic signed [TEMP_W-1:0] t_rd_q;
  logic [COEF_W-1:0] d_rd_q;

  logic [AW-1:0] rd_addr;
  logic t_we;
  logic [AW-1:0] t_waddr;
  logic signed [TEMP_W-1:0] t_wdata;
  logic d_we;

  logic in_acc;
  logic in_range;
  logic out_free;
  logic last_interior;

  logic [AW-1:0] addr_q;
  logic oob_q;
  logic [IDX_W-1:0] idx_q;
  logic [AW-1:0] i_q;

  logic signed [TEMP_W-1:0] left_q, mid_q, right_q;
  logic [COEF_W-1:0] dl_q, dr_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [BRK_MSB-BRK_SPLIT:0] hi_q;

  logic signed [MUL_W-1:0] ma, mb;
  logic signed [PROD_W-1:0] mp;

  logic signed [ACC_W-1:0] rnd;
  logic signed [INC_W-1:0] inc;
  logic signed [SUM_W-1:0] sum;
  logic signed [TEMP_W-1:0] upd_temp;
  logic upd_sat;

  logic emit;
  logic [IDX_W-1:0] e_idx;
  logic signed [TEMP_W-1:0] e_temp;
  logic e_sat;
  logic e_last;

  logic out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic out_sat_q;
  logic out_last_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_range = 32'(cell_index_i) < MAX_CELLS;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cells_q < CELLS_MIN) begin
      n_cells = CW'(3);
    end else if (32'(cells_q) > MAX_CELLS) begin
      n_cells = CW'(MAX_CELLS);
    end else begin
      n_cells = CW'(cells_q);
    end
  end

  assign last_interior = (CW'(i_q) + CW'(1)) == (n_cells - CW'(1));

  assign mp = ma * mb;

  assign rnd = acc_q + $signed(ROUND_HALF);
  assign inc = rnd[ACC_W-1:FRAC_SHIFT];
  assign sum = SUM_W'(mid_q) + SUM_W'(inc);

  always_comb begin
    upd_sat = 1'b1;
    if (sum > TEMP_MAX) begin
      upd_temp = TEMP_W'(TEMP_MAX);
    end else if (sum < TEMP_MIN) begin
      upd_temp = TEMP_W'(TEMP_MIN);
    end else begin
      upd_temp = TEMP_W'(sum);
      upd_sat = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_e'(operation_i))
            OP_STEP: state_d = ST_HEAD;
            OP_RD_TEMP: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: if (out_free) state_d = ST_IDLE;
      ST_HEAD: state_d = ST_PRIME;
      ST_PRIME: state_d = ST_EMIT0;
      ST_EMIT0: if (out_free) state_d = ST_MUL_L;
      ST_MUL_L: state_d = ST_MUL_R;
      ST_MUL_R: state_d = ST_GAIN_LO;
      ST_GAIN_LO: state_d = ST_GAIN_HI;
      ST_GAIN_HI: state_d = ST_WRITE;
      ST_WRITE: begin
        if (out_free) begin
          state_d = last_interior ? ST_TAIL : ST_MUL_L;
        end
      end
      ST_TAIL: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = AW'(i_q) + AW'(1);
    t_we = 1'b0;
    t_waddr = i_q;
    t_wdata = '0;
    d_we = 1'b0;
    ma = '0;
    mb = $signed({2'b00, gain_q});
    emit = 1'b0;
    e_idx = IDX_W'(i_q);
    e_temp = '0;
    e_sat = 1'b0;
    e_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr = (operation_i == OP_RD_TEMP && in_range) ? AW'(cell_index_i) : '0;
        t_waddr = AW'(cell_index_i);
        t_wdata = temperature_in_i;
        t_we = in_acc && operation_i == OP_WR_TEMP && in_range;
        d_we = in_acc && operation_i == OP_WR_COEF && in_range;
      end
      ST_READ: begin
        rd_addr = addr_q;
        emit = out_free;
        e_idx = idx_q;
        e_temp = oob_q ? '0 : t_rd_q;
        e_last = 1'b1;
      end
      ST_HEAD: begin
        rd_addr = AW'(1);
        t_we = 1'b1;
        t_waddr = '0;
      end
      ST_PRIME: begin
      end
      ST_EMIT0: begin
        emit = out_free;
        e_idx = '0;
      end
      ST_MUL_L: begin
        ma = MUL_W'(left_q) - MUL_W'(mid_q);
        mb = $signed({2'b00, dl_q});
      end
      ST_MUL_R: begin
        ma = MUL_W'(t_rd_q) - MUL_W'(mid_q);
        mb = $signed({2'b00, d_rd_q});
      end
      ST_GAIN_LO: begin
        ma = $signed({1'b0, acc_q[BRK_SPLIT-1:0]});
      end
      ST_GAIN_HI: begin
        ma = MUL_W'(hi_q);
      end
      ST_WRITE: begin
        t_we = out_free;
        t_wdata = upd_temp;
        emit = out_free;
        e_temp = upd_temp;
        e_sat = upd_sat;
      end
      ST_TAIL: begin
        t_we = out_free;
        emit = out_free;
        e_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      temps[t_waddr] <= t_wdata;
    end
    t_rd_q <= temps[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      coefs[AW'(cell_index_i)] <= coefficient_in_i;
    end
    d_rd_q <= coefs[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gain_q <= '0;
      cells_q <= CELLS_RESET;
      out_valid_q <= 1'b0;
      left_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_STEP_GAIN: gain_q <= cfg_data_i;
          CFG_CELLS_IN_USE: cells_q <= cfg_data_i[CELLS_W-1:0];
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_HEAD) begin
        left_q <= t_rd_q;
      end else if (state_q == ST_WRITE && out_free) begin
        left_q <= mid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_idx_q <= e_idx;
      out_temp_q <= e_temp;
      out_sat_q <= e_sat;
      out_last_q <= e_last;
    end
    if (in_acc) begin
      addr_q <= rd_addr;
      oob_q <= !in_range;
      idx_q <= cell_index_i;
      i_q <= AW'(1);
    end
    case (state_q)
      ST_PRIME: begin
        mid_q <= t_rd_q;
        dl_q <= d_rd_q;
      end
      ST_MUL_L: acc_q <= ACC_W'(mp);
      ST_MUL_R: begin
        acc_q <= acc_q + ACC_W'(mp);
        right_q <= t_rd_q;
        dr_q <= d_rd_q;
      end
      ST_GAIN_LO: begin
        hi_q <= acc_q[BRK_MSB:BRK_SPLIT];
        acc_q <= ACC_W'(mp);
      end
      ST_GAIN_HI: acc_q <= acc_q + (ACC_W'(mp) <<< BRK_SPLIT);
      ST_WRITE: begin
        if (out_free) begin
          mid_q <= right_q;
          dl_q <= dr_q;
          i_q <= i_q + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign cell_index_out_o = out_idx_q;
  assign temperature_out_o = out_temp_q;
  assign saturated_o = out_sat_q;
  assign last_o = out_last_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_valid_q |-> !out_stall_i)
    else $error("A new word replaced a stalled output word.");

  a_sweep_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_L || state_q == ST_MUL_R || state_q == ST_GAIN_LO ||
     state_q == ST_GAIN_HI || state_q == ST_WRITE)
    |-> i_q != '0 && (CW'(i_q) + CW'(1)) < n_cells)
    else $error("The sweep index left the interior cells.");

  a_low_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GAIN_HI |-> !acc_q[ACC_W-1])
    else $error("The low partial product came out negative.");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && e_last |-> state_q == ST_TAIL || state_q == ST_READ)
    else $error("The last flag was raised inside a sweep.");
`endif

endmodule

@@ sim/heat_equation_step_checker.sv @@
// Checker for the explicit heat equation step: watches the configuration port and both
// channels, keeps its own copy of the grid, predicts every output word and compares it.
// Depends on heat_eq_pkg.
module heat_equation_step_checker
  import heat_eq_pkg::*;
#(
  parameter int MAX_CELLS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [GAIN_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [OP_W-1:0]          operation_i,
  input  logic [IDX_W-1:0]         cell_index_i,
  input  logic signed [TEMP_W-1:0] temperature_in_i,
  input  logic [COEF_W-1:0]        coefficient_in_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [IDX_W-1:0]         cell_index_out_i,
  input  logic signed [TEMP_W-1:0] temperature_out_i,
  input  logic                     saturated_i,
  input  logic                     last_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]         cell_idx;
    logic signed [TEMP_W-1:0] temp;
    logic                     sat;
    logic                     last;
  } cell_report_t;

  logic [GAIN_W-1:0]         gain_q;
  logic [CELLS_W-1:0]        cells_q;
  logic signed [TEMP_W-1:0]  grid_temp [MAX_CELLS];
  logic [COEF_W-1:0]         grid_coef [MAX_CELLS];
  logic signed [TEMP_W-1:0]  left_old;
  cell_report_t              expected_cells [$];
  cell_report_t              want;
  logic                      bad;

  task automatic queue_report(input int cell_idx, input logic signed [TEMP_W-1:0] temp,
                              input logic sat, input logic fin);
    cell_report_t r;
    r.cell_idx = IDX_W'(cell_idx);
    r.temp = temp;
    r.sat  = sat;
    r.last = fin;
    expected_cells.push_back(r);
  endtask

  task automatic sweep_grid();
    int     n;
    longint left, mid, right, dl, dr, bracket, incr, upd;
    logic   sat;
    n = int'(cells_q);
    if (n < 3) n = 3;
    if (n > MAX_CELLS) n = MAX_CELLS;
    left_old = grid_temp[0];
    grid_temp[0] = '0;
    queue_report(0, '0, 1'b0, 1'b0);
    for (int i = 1; i < n - 1; i++) begin
      left    = longint'(left_old);
      mid     = longint'(grid_temp[i]);
      right   = longint'(grid_temp[i+1]);
      dl      = longint'(grid_coef[i]);
      dr      = longint'(grid_coef[i+1]);
      bracket = dl * left - (dl + dr) * mid + dr * right;
      incr    = (bracket * longint'(gain_q) + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      upd     = mid + incr;
      sat     = 1'b0;
      if (upd > 32767) begin
        upd = 32767;
        sat = 1'b1;
      end else if (upd < -32768) begin
        upd = -32768;
        sat = 1'b1;
      end
      left_old = grid_temp[i];
      grid_temp[i] = TEMP_W'(upd);
      queue_report(i, grid_temp[i], sat, 1'b0);
    end
    left_old = grid_temp[n-1];
    grid_temp[n-1] = '0;
    queue_report(n - 1, '0, 1'b0, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       = '0;
      cells_q      = CELLS_RESET;
      left_old     = '0;
      expected_cells.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected word: cell_index_out %0d temperature_out %0d",
                 cell_index_out_i, temperature_out_i);
          fail_count_o++;
        end else begin
          want = expected_cells.pop_front();
          bad  = 1'b0;
          if (cell_index_out_i !== want.cell_idx) begin
            $error("cell_index_out: expected %0d, got %0d", want.cell_idx, cell_index_out_i);
            bad = 1'b1;
          end
          if (temperature_out_i !== want.temp) begin
            $error("temperature_out: expected %0d, got %0d", want.temp, temperature_out_i);
            bad = 1'b1;
          end
          if (saturated_i !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, saturated_i);
            bad = 1'b1;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            bad = 1'b1;
          end
          if (bad) fail_count_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_STEP_GAIN:    gain_q = cfg_data_i;
          CFG_CELLS_IN_USE: cells_q = cfg_data_i[CELLS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_e'(operation_i))
          OP_WR_TEMP: begin
            if (int'(cell_index_i) < MAX_CELLS) grid_temp[cell_index_i] = temperature_in_i;
          end
          OP_WR_COEF: begin
            if (int'(cell_index_i) < MAX_CELLS) grid_coef[cell_index_i] = coefficient_in_i;
          end
          OP_RD_TEMP: begin
            if (int'(cell_index_i) < MAX_CELLS)
              queue_report(int'(cell_index_i), grid_temp[cell_index_i], 1'b0, 1'b1);
            else
              queue_report(int'(cell_index_i), '0, 1'b0, 1'b1);
          end
          default: sweep_grid();
        endcase
      end
      pending_o = expected_cells.size();
    end
  end

endmodule

@@ sim/tb_heat_equation_explicit_step.sv @@
// Testbench top for the explicit heat equation step: clock, reset, configuration phases and
// stimulus with random idling on both channels; the verdict comes from the checker's count.
// Depends on heat_eq_pkg, heat_equation_explicit_step and heat_equation_step_checker.
module tb_heat_equation_explicit_step
  import heat_eq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 36;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [GAIN_W-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          operation;
  logic [IDX_W-1:0]         cell_index;
  logic signed [TEMP_W-1:0] temperature_in;
  logic [COEF_W-1:0]        coefficient_in;
  logic                     out_valid;
  logic                     out_stall;
  logic [IDX_W-1:0]         cell_index_out;
  logic signed [TEMP_W-1:0] temperature_out;
  logic                     saturated;
  logic                     last_out;
  int                       fail_count;
  int                       pending;
  int                       send_idle_pct;
  int                       recv_idle_pct;

  heat_equation_explicit_step #(
    .MAX_CELLS(32)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .cell_index_i      (cell_index),
    .temperature_in_i  (temperature_in),
    .coefficient_in_i  (coefficient_in),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .cell_index_out_o  (cell_index_out),
    .temperature_out_o (temperature_out),
    .saturated_o       (saturated),
    .last_o            (last_out)
  );

  heat_equation_step_checker #(
    .MAX_CELLS(32)
  ) checker_inst (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .operation_i       (operation),
    .cell_index_i      (cell_index),
    .temperature_in_i  (temperature_in),
    .coefficient_in_i  (coefficient_in),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .cell_index_out_i  (cell_index_out),
    .temperature_out_i (temperature_out),
    .saturated_i       (saturated),
    .last_i            (last_out),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic signed [TEMP_W-1:0] pick_temperature();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(2))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          default: return '0;
        endcase
      end
      1:       return TEMP_W'($urandom_range(8192)) - TEMP_W'(4096);
      default: return TEMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coefficient();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(2))
          0:       return 16'hFFFF;
          1:       return 16'h4000;
          default: return '0;
        endcase
      end
      1:       return COEF_W'($urandom_range(4096));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic signed [TEMP_W-1:0] temp,
                           input logic [COEF_W-1:0] coef);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    cell_index     <= idx;
    temperature_in <= temp;
    coefficient_in <= coef;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_grid(input logic [GAIN_W-1:0] gain, input logic [GAIN_W-1:0] cells_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP_GAIN;
    cfg_data  <= gain;
    @(negedge clk);
    cfg_index <= CFG_CELLS_IN_USE;
    cfg_data  <= cells_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    #5ms;
    $display("FAIL heat_equation_explicit_step");
    $finish;
  end

  initial begin
    logic [31:0] rnd;
    logic [GAIN_W-1:0] gain;
    logic [GAIN_W-1:0] cells_word;
    int pick;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    operation      = '0;
    cell_index     = '0;
    temperature_in = '0;
    coefficient_in = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      rnd = $urandom;
      case (phase)
        0: begin
          gain = 16'hFFFF;
          cells_word = 16'd5;
        end
        1: begin
          gain = '0;
          cells_word = 16'd32;
        end
        2: begin
          gain = GAIN_W'($urandom);
          cells_word = {rnd[15:6], 6'd3};
        end
        3: begin
          gain = 16'hFFFF;
          cells_word = {rnd[15:6], 6'd2};
        end
        4: begin
          gain = GAIN_W'($urandom);
          cells_word = {rnd[15:6], 6'd63};
        end
        default: begin
          gain = GAIN_W'($urandom_range(4096));
          cells_word = rnd[15:0];
        end
      endcase
      set_grid(gain, cells_word);

      if (phase == 0) begin
        for (int c = 0; c < 32; c++) begin
          send_word(OP_WR_TEMP, IDX_W'(c), pick_temperature(), COEF_W'($urandom));
          send_word(OP_WR_COEF, IDX_W'(c), TEMP_W'($urandom), pick_coefficient());
        end
        send_word(OP_WR_TEMP, 5'd0, 16'sh7FFF, 16'h0000);
        send_word(OP_WR_TEMP, 5'd1, 16'sh8000, 16'hFFFF);
        send_word(OP_WR_TEMP, 5'd2, 16'sh7FFF, 16'h0000);
        send_word(OP_WR_TEMP, 5'd3, 16'sh0000, 16'hFFFF);
        send_word(OP_WR_TEMP, 5'd4, 16'shFFFF, 16'h0000);
        send_word(OP_WR_COEF, 5'd1, 16'sh0000, 16'hFFFF);
        send_word(OP_WR_COEF, 5'd2, 16'shFFFF, 16'h0000);
        send_word(OP_WR_COEF, 5'd3, 16'sh0000, 16'hFFFF);
        send_word(OP_WR_COEF, 5'd4, 16'shFFFF, 16'h0001);
        send_word(OP_RD_TEMP, 5'd1, 16'sh0000, 16'h0000);
        send_word(OP_RD_TEMP, 5'd31, 16'shFFFF, 16'hFFFF);
        send_word(OP_STEP, 5'd0, 16'sh0000, 16'h0000);
        send_word(OP_RD_TEMP, 5'd0, 16'sh0000, 16'h0000);
        send_word(OP_RD_TEMP, 5'd4, 16'sh0000, 16'h0000);
        send_word(OP_STEP, 5'd31, 16'shFFFF, 16'hFFFF);
        send_word(OP_WR_TEMP, 5'd1, 16'sh1000, 16'h0000);
        send_word(OP_WR_TEMP, 5'd2, -16'sh1000, 16'h0000);
        send_word(OP_WR_COEF, 5'd2, 16'sh0000, 16'h4000);
        send_word(OP_STEP, 5'd0, 16'sh0000, 16'h0000);
        send_word(OP_RD_TEMP, 5'd2, 16'sh0000, 16'h0000);
      end

      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        pick = $urandom_range(99);
        if (pick < 35)
          send_word(OP_WR_TEMP, IDX_W'($urandom), pick_temperature(), COEF_W'($urandom));
        else if (pick < 60)
          send_word(OP_WR_COEF, IDX_W'($urandom), TEMP_W'($urandom), pick_coefficient());
        else if (pick < 80)
          send_word(OP_STEP, IDX_W'($urandom), TEMP_W'($urandom), COEF_W'($urandom));
        else
          send_word(OP_RD_TEMP, IDX_W'($urandom), TEMP_W'($urandom), COEF_W'($urandom));
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS heat_equation_explicit_step");
    end else begin
      $display("FAIL heat_equation_explicit_step");
    end
    $finish;
  end

endmodule
